// ----- rtl/melody_tone_sequencer_top_assert.svh -----
// assertion macros for the melody tone sequencer
// used by melody_tone_sequencer_top, needs clk and rst_n in scope
`ifndef MELODY_TONE_SEQUENCER_TOP_ASSERT_SVH
`define MELODY_TONE_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define MTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("melody tone sequencer check failed");

// next-cycle implication, held off during reset
`define MTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("melody tone sequencer check failed");

`endif

// ----- rtl/mts_pkg.sv -----
// shared types, constants and pitch table for the melody tone sequencer
// no dependencies
`default_nettype none
package mts_pkg;

  localparam int MAX_NOTES = 256;
  localparam int IDX_W     = $clog2(MAX_NOTES);
  localparam int CNT_W     = $clog2(MAX_NOTES + 1);
  localparam int PER_W     = 11;
  localparam int LEN_W     = 16;
  localparam int OP_W      = 3;
  localparam int CHAR_W    = 8;

  localparam logic [PER_W-1:0] REST_CODE   = PER_W'(1);
  localparam logic [LEN_W-1:0] FULL_LENGTH = {LEN_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN = 3'd0,
    OP_CHAR  = 3'd1,
    OP_END   = 3'd2,
    OP_TICK  = 3'd3,
    OP_STOP  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    PH_PITCH  = 2'd0,
    PH_OCTAVE = 2'd1,
    PH_LENGTH = 2'd2
  } phase_t;

  typedef struct packed {
    logic [PER_W-1:0] per;
    logic [LEN_W-1:0] len;
  } note_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    note_t            data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  // half-period for a pitch letter, rest code for anything else
  function automatic logic [PER_W-1:0] pitch_period(input logic [CHAR_W-1:0] c);
    logic [PER_W-1:0] p;
    begin
      case (c)
        "c":     p = PER_W'(1437);
        "C":     p = PER_W'(1356);
        "d":     p = PER_W'(1281);
        "D":     p = PER_W'(1208);
        "e":     p = PER_W'(1141);
        "f":     p = PER_W'(1077);
        "F":     p = PER_W'(1016);
        "g":     p = PER_W'(959);
        "G":     p = PER_W'(905);
        "a":     p = PER_W'(855);
        "A":     p = PER_W'(807);
        "b":     p = PER_W'(761);
        default: p = REST_CODE;
      endcase
      return p;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/melody_tone_sequencer_top.sv -----
// melody tone sequencer: song loader, note sequencer and square-wave tone generator
// uses mts_pkg, mts_note_store and melody_tone_sequencer_top_assert.svh
//
// input channel (in_valid / in_stall) carries one operation per transfer:
//   begin song, song character, end song, timer tick or stop.
// output channel (out_valid / out_stall) returns one result per input transfer:
//   speaker level, playing flag, note position, stored note count, accepted flag.
// each result is registered in the output register, or in the skid register on a stall.
// throughput: one item per cycle while in_stall is low; the note memory prefetches the
//   note after the current one on every transfer, so each tick finds its next note in a register.
// when the receiver stalls, a second result is parked in a skid register and
//   in_stall rises only once both output registers are full.
// reset clears all control state; the note memory needs no clearing pass, only
//   entries below the stored count are ever used.
`default_nettype none
`include "melody_tone_sequencer_top_assert.svh"
module melody_tone_sequencer_top (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [mts_pkg::OP_W-1:0]    in_operation,
  input  wire  [mts_pkg::CHAR_W-1:0]  in_char_code,
  input  wire                         in_loop_request,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        out_speaker,
  output logic                        out_is_playing,
  output logic [mts_pkg::CNT_W-1:0]   out_position,
  output logic [mts_pkg::CNT_W-1:0]   out_notes_stored,
  output logic                        out_accepted
);
  import mts_pkg::*;

  typedef struct packed {
    logic             speaker;
    logic             playing;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] stored;
    logic             accepted;
  } result_t;

  // sequencer state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [PER_W-1:0] pend_r, pend_nxt;
  logic [LEN_W-1:0] tone_r, tone_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [PER_W-1:0] cur_per_r, cur_per_nxt;
  logic             play_r, play_nxt;
  logic             loop_r, loop_nxt;
  logic             loading_r, loading_nxt;
  logic             spk_r, spk_nxt;

  // output stage
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t res;

  wr_req_t wr;
  rd_req_t rd;
  note_t   next_note;
  note_t   first_note;
  note_t   tgt;
  logic    acc;
  logic    in_acc;
  logic    out_take;
  logic [CNT_W-1:0] pos_inc;
  logic [CHAR_W-1:0] ch;

  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign pos_inc  = pos_r + CNT_W'(1);
  assign ch       = in_char_code;

  mts_note_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .rd         (rd),
    .next_note  (next_note),
    .first_note (first_note)
  );

  always_comb begin
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    pend_nxt    = pend_r;
    tone_nxt    = tone_r;
    len_nxt     = len_r;
    cur_per_nxt = cur_per_r;
    play_nxt    = play_r;
    loop_nxt    = loop_r;
    loading_nxt = loading_r;
    spk_nxt     = spk_r;
    acc         = 1'b0;
    wr          = '0;
    tgt         = '{per: REST_CODE, len: '0};

    if (in_acc) begin
      case (op_t'(in_operation))
        OP_BEGIN: begin
          if (!play_r || loop_r) begin
            play_nxt    = 1'b1;
            loop_nxt    = in_loop_request;
            loading_nxt = 1'b1;
            count_nxt   = '0;
            pos_nxt     = '0;
            phase_nxt   = PH_PITCH;
            cur_per_nxt = REST_CODE;
            acc         = 1'b1;
          end
        end
        OP_CHAR: begin
          if (loading_r) begin
            acc = 1'b1;
            case (phase_r)
              PH_PITCH: begin
                pend_nxt  = pitch_period(ch);
                phase_nxt = PH_OCTAVE;
              end
              PH_OCTAVE: begin
                if (pend_r != REST_CODE) begin
                  pend_nxt = pend_r >> ch[3:0];
                end
                phase_nxt = PH_LENGTH;
              end
              default: begin
                // a full store drops the note but still takes the character
                if (count_r < CNT_W'(MAX_NOTES)) begin
                  wr.en       = 1'b1;
                  wr.addr     = count_r[IDX_W-1:0];
                  wr.data.per = pend_r;
                  wr.data.len = FULL_LENGTH >> ch[3:0];
                  count_nxt   = count_r + CNT_W'(1);
                end
                phase_nxt = PH_PITCH;
              end
            endcase
          end
        end
        OP_END: begin
          if (loading_r) begin
            loading_nxt = 1'b0;
            phase_nxt   = PH_PITCH;
            pos_nxt     = '0;
            acc         = 1'b1;
            if (count_r != '0) begin
              len_nxt     = first_note.len;
              tone_nxt    = LEN_W'(first_note.per);
              cur_per_nxt = first_note.per;
            end else begin
              len_nxt     = '0;
              tone_nxt    = LEN_W'(REST_CODE);
              cur_per_nxt = REST_CODE;
            end
          end
        end
        OP_TICK: begin
          if (!loading_r) begin
            if (len_r <= LEN_W'(1)) begin
              // note expired: pick the following slot
              if (loop_r) begin
                if (!play_r || (count_r == '0)) begin
                  pos_nxt = play_r ? '0 : count_r;
                end else if (pos_inc >= count_r) begin
                  pos_nxt = '0;
                  tgt     = first_note;
                end else begin
                  pos_nxt = pos_inc;
                  tgt     = next_note;
                end
              end else begin
                if (pos_r >= count_r) begin
                  play_nxt = 1'b0;
                end else begin
                  pos_nxt = pos_inc;
                  if (pos_inc < count_r) begin
                    tgt = next_note;
                  end
                end
              end
              len_nxt     = tgt.len;
              cur_per_nxt = tgt.per;
            end else begin
              len_nxt = len_r - LEN_W'(1);
            end

            if (tone_r <= LEN_W'(1)) begin
              if (cur_per_nxt != REST_CODE) begin
                spk_nxt  = !spk_r;
                tone_nxt = LEN_W'(cur_per_nxt);
              end else begin
                // rest waits out the note length
                tone_nxt = len_nxt;
              end
            end else begin
              tone_nxt = tone_r - LEN_W'(1);
            end
          end
        end
        OP_STOP: begin
          play_nxt    = 1'b0;
          loading_nxt = 1'b0;
          phase_nxt   = PH_PITCH;
          pos_nxt     = count_r;
          len_nxt     = '0;
          tone_nxt    = '0;
          cur_per_nxt = REST_CODE;
        end
        default: begin
        end
      endcase
    end
  end

  // prefetch the note after the new position on every transfer
  always_comb begin
    rd.en   = in_acc;
    rd.addr = IDX_W'(pos_nxt + CNT_W'(1));
  end

  always_comb begin
    res.speaker  = spk_nxt;
    res.playing  = play_nxt;
    res.position = pos_nxt;
    res.stored   = count_nxt;
    res.accepted = acc;
  end

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (in_acc) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      // receiver stalled: park this transfer's result
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pos_r        <= '0;
      phase_r      <= PH_PITCH;
      pend_r       <= '0;
      tone_r       <= '0;
      len_r        <= '0;
      cur_per_r    <= REST_CODE;
      play_r       <= 1'b0;
      loop_r       <= 1'b0;
      loading_r    <= 1'b0;
      spk_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      pos_r        <= pos_nxt;
      phase_r      <= phase_nxt;
      pend_r       <= pend_nxt;
      tone_r       <= tone_nxt;
      len_r        <= len_nxt;
      cur_per_r    <= cur_per_nxt;
      play_r       <= play_nxt;
      loop_r       <= loop_nxt;
      loading_r    <= loading_nxt;
      spk_r        <= spk_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall         = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_speaker      = out_r.speaker;
  assign out_is_playing   = out_r.playing;
  assign out_position     = out_r.position;
  assign out_notes_stored = out_r.stored;
  assign out_accepted     = out_r.accepted;

  `MTS_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `MTS_ASSERT_NOW(a_pos_in_song, 1'b1, pos_r <= count_r)
  `MTS_ASSERT_NOW(a_loading_plays, loading_r, play_r)
  `MTS_ASSERT_NEXT(a_stop_halts, in_acc && (in_operation == OP_STOP), !play_r && !loading_r)

endmodule
`default_nettype wire

// ----- rtl/mts_note_store.sv -----
// note memory: one write port at the load pointer, one prefetch read port
// keeps a copy of the first note for end-of-load and wrap; uses mts_pkg
`default_nettype none
module mts_note_store (
  input  wire              clk,
  input  wire              rst_n,
  input  mts_pkg::wr_req_t wr,
  input  mts_pkg::rd_req_t rd,
  output mts_pkg::note_t   next_note,
  output mts_pkg::note_t   first_note
);
  import mts_pkg::*;

  note_t mem [MAX_NOTES];
  note_t rdata_r;
  note_t hold_r;
  note_t first_r;
  logic  fresh_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == '0)) begin
      first_r <= wr.data;
    end
    if (fresh_r) begin
      hold_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b0;
    end else begin
      fresh_r <= rd.en;
    end
  end

  // read data lands in rdata_r in the cycle after the request, then moves to the hold copy
  assign next_note  = fresh_r ? rdata_r : hold_r;
  assign first_note = first_r;

endmodule
`default_nettype wire
